### design/ffha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// shared beat types, status codes and sequencer states of the heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int unsigned ALIGN_BYTES = 4;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOFIT   = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ALLOC   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] request_size;
      logic [15:0] payload_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_offset;
      logic [16:0] used_bytes;
      logic [16:0] free_bytes;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_A_RD,
      S_A_WAIT,
      S_A_CHK,
      S_A_SPLIT_NB,
      S_A_AFT_RD,
      S_A_AFT_WAIT,
      S_A_AFT_WR,
      S_A_CUR_WR,
      S_R_RD,
      S_R_WAIT,
      S_R_MARK,
      S_R_N_RD,
      S_R_N_WAIT,
      S_R_N_MERGE,
      S_R_NN_RD,
      S_R_NN_WAIT,
      S_R_NN_WR,
      S_R_N_CLR,
      S_R_P_RD,
      S_R_P_WAIT,
      S_R_P_CHK,
      S_R_A_RD,
      S_R_A_WAIT,
      S_R_A_WR,
      S_R_O_CLR,
      S_R_P_WR,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

### design/ffha_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

### design/first_fit_heap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap allocator with coalescing of free neighbors
// ----------------------------------------------------------------------------
// One beat at a time. After reset a clearing pass walks every header ram
// word, one word per cycle, while req_ready stays low. An allocate reads and
// checks each block, on a split writes the new free block and re-links any
// block after it, marks the granted block and loads the response register;
// a zero size goes straight to the response. An out-of-range release is
// answered after its check, one of an unused block after its header read,
// one freeing a block after any merges with free neighbors. The single-port
// header ram sets the rate. A stalled response beat is held in its own
// register while the next beat is worked on; the sequencer then waits in its
// response state until that register frees up. Header word: size in the top
// bits, then the used mark and the predecessor offset.
module first_fit_heap_allocator #(
   parameter int unsigned HEAP_BYTES   = 65536,
   parameter int unsigned HEADER_BYTES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffha_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffha_pkg::rsp_type      rsp_data
);
   import ffha_pkg::*;

   localparam int unsigned WORDS = HEAP_BYTES / 4;
   localparam int unsigned AW    = $clog2(WORDS);
   localparam int unsigned OW    = AW + 2;        // byte offset width
   localparam int unsigned SW    = OW + 1;        // size / pointer width
   localparam int unsigned HW    = SW + 1 + OW;   // header word width
   localparam logic [SW-1:0] HEAP_S = SW'(HEAP_BYTES);
   localparam logic [SW-1:0] HDR_S  = SW'(HEADER_BYTES);

   typedef struct packed {
      logic [SW-1:0] size;
      logic          used;
      logic [OW-1:0] prev;
   } hdr_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] cur_ff, cur_in, asz_ff, asz_in, nb_ff, nb_in, n_ff, n_in;
   logic [SW-1:0] off_ff, off_in;
   hdr_type h_ff, h_in, o_ff, o_in;
   logic [16:0] used_ff, used_in, free_ff, free_in;

   logic          wr_en;
   logic [AW-1:0] addr;
   hdr_type       wr_data, rd_data;
   logic [HW-1:0] rd_raw;

   ffha_ram #(.WIDTH(HW), .DEPTH(WORDS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(wr_data),
      .rd_data(rd_raw)
   );
   assign rd_data = hdr_type'(rd_raw);

   function automatic logic [AW-1:0] wa(input logic [SW-1:0] b);
      return b[AW+1:2];
   endfunction

   logic [SW-1:0] pay_s, next_cur, next_o, asz_calc;
   assign pay_s    = SW'(req_ff.payload_offset);
   assign next_cur = cur_ff + HDR_S + rd_data.size;
   assign next_o   = off_ff + HDR_S + o_ff.size;
   assign asz_calc = (SW'(req_ff.request_size) + SW'(3)) & ~SW'(3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= 17'(HEADER_BYTES);
         free_ff      <= 17'(HEAP_BYTES - HEADER_BYTES);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      out_ff <= out_in;
      cur_ff <= cur_in;
      asz_ff <= asz_in;
      nb_ff  <= nb_in;
      n_ff   <= n_in;
      off_ff <= off_in;
      h_ff   <= h_in;
      o_ff   <= o_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(WORDS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == KIND_ALLOC) begin
                  state_in = (req_data.request_size == '0) ? S_RESP : S_A_RD;
               end else begin
                  state_in = S_R_RD;
               end
            end
         end
         S_A_RD:   state_in = S_A_WAIT;
         S_A_WAIT: state_in = S_A_CHK;
         S_A_CHK: begin
            priority if (!rd_data.used && rd_data.size >= asz_ff) begin
               state_in = (rd_data.size > asz_ff + HDR_S + SW'(4)) ? S_A_SPLIT_NB
                                                                    : S_A_CUR_WR;
            end else if (next_cur >= HEAP_S) begin
               state_in = S_RESP;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_A_SPLIT_NB: state_in = (cur_ff + HDR_S + h_ff.size >= HEAP_S) ? S_A_CUR_WR
                                                                          : S_A_AFT_RD;
         S_A_AFT_RD:   state_in = S_A_AFT_WAIT;
         S_A_AFT_WAIT: state_in = S_A_AFT_WR;
         S_A_AFT_WR:   state_in = S_A_CUR_WR;
         S_A_CUR_WR:   state_in = S_RESP;
         S_R_RD: begin
            state_in = (pay_s < HDR_S || pay_s[1:0] != 2'b00 ||
                        pay_s - HDR_S >= HEAP_S) ? S_RESP : S_R_WAIT;
         end
         S_R_WAIT: state_in = S_R_MARK;
         S_R_MARK: state_in = rd_data.used ? S_R_N_RD : S_RESP;
         S_R_N_RD: state_in = (next_o >= HEAP_S) ? S_R_P_RD : S_R_N_WAIT;
         S_R_N_WAIT: state_in = S_R_N_MERGE;
         S_R_N_MERGE: state_in = rd_data.used ? S_R_P_RD : S_R_NN_RD;
         S_R_NN_RD: state_in = (n_ff + HDR_S + h_ff.size >= HEAP_S) ? S_R_N_CLR
                                                                      : S_R_NN_WAIT;
         S_R_NN_WAIT: state_in = S_R_NN_WR;
         S_R_NN_WR:   state_in = S_R_N_CLR;
         S_R_N_CLR:   state_in = S_R_P_RD;
         S_R_P_RD:    state_in = (off_ff == '0) ? S_RESP : S_R_P_WAIT;
         S_R_P_WAIT:  state_in = S_R_P_CHK;
         S_R_P_CHK:   state_in = rd_data.used ? S_RESP : S_R_A_RD;
         S_R_A_RD:    state_in = (next_o >= HEAP_S) ? S_R_O_CLR : S_R_A_WAIT;
         S_R_A_WAIT:  state_in = S_R_A_WR;
         S_R_A_WR:    state_in = S_R_O_CLR;
         S_R_O_CLR:   state_in = S_R_P_WR;
         S_R_P_WR:    state_in = S_RESP;
         S_RESP:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
      if (rsp_valid_ff && !rsp_ready && state_ff == S_RESP) state_in = S_RESP;
   end

   // datapath and ram control
   always_comb begin
      clr_in = clr_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cur_in = cur_ff;
      asz_in = asz_ff;
      nb_in  = nb_ff;
      n_in   = n_ff;
      off_in = off_ff;
      h_in   = h_ff;
      o_in   = o_ff;
      used_in = used_ff;
      free_in = free_ff;
      wr_en   = 1'b0;
      addr    = '0;
      wr_data = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            addr  = clr_ff;
            if (clr_ff == '0) wr_data.size = HEAP_S - HDR_S;
            clr_in = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cur_in = '0;
               rsp_in.status = ST_DONE;
               rsp_in.granted_offset = '0;
               if (req_data.kind == KIND_ALLOC && req_data.request_size == '0) begin
                  rsp_in.status = ST_ZERO;
               end
            end
         end
         S_A_RD: begin
            addr = wa(cur_ff);
            asz_in = asz_calc;
         end
         S_A_WAIT: addr = wa(cur_ff);
         S_A_CHK: begin
            h_in = rd_data;
            if (!rd_data.used && rd_data.size >= asz_ff) begin
               nb_in = cur_ff + HDR_S + asz_ff;
            end else if (next_cur >= HEAP_S) begin
               rsp_in.status = ST_NOFIT;
            end else begin
               cur_in = next_cur;
            end
         end
         S_A_SPLIT_NB: begin
            wr_en = 1'b1;
            addr  = wa(nb_ff);
            wr_data.size = h_ff.size - asz_ff - HDR_S;
            wr_data.used = 1'b0;
            wr_data.prev = OW'(cur_ff);
            n_in = cur_ff + HDR_S + h_ff.size;
            h_in.size = asz_ff;
         end
         S_A_AFT_RD, S_A_AFT_WAIT: addr = wa(n_ff);
         S_A_AFT_WR: begin
            wr_en = 1'b1;
            addr  = wa(n_ff);
            wr_data = rd_data;
            wr_data.prev = OW'(nb_ff);
         end
         S_A_CUR_WR: begin
            wr_en = 1'b1;
            addr  = wa(cur_ff);
            wr_data = h_ff;
            wr_data.used = 1'b1;
            used_in = used_ff + 17'(h_ff.size);
            free_in = free_ff - 17'(h_ff.size);
            rsp_in.granted_offset = 16'(cur_ff + HDR_S);
         end
         S_R_RD: begin
            off_in = pay_s - HDR_S;
            addr   = wa(pay_s - HDR_S);
            if (pay_s < HDR_S || pay_s[1:0] != 2'b00 || pay_s - HDR_S >= HEAP_S) begin
               rsp_in.status = ST_IGNORED;
            end
         end
         S_R_WAIT: addr = wa(off_ff);
         S_R_MARK: begin
            addr = wa(off_ff);
            o_in = rd_data;
            o_in.used = 1'b0;
            if (rd_data.used) begin
               wr_en = 1'b1;
               wr_data = rd_data;
               wr_data.used = 1'b0;
               used_in = used_ff - 17'(rd_data.size);
               free_in = free_ff + 17'(rd_data.size);
            end else begin
               rsp_in.status = ST_IGNORED;
            end
         end
         S_R_N_RD: begin
            n_in = next_o;
            addr = wa(next_o);
         end
         S_R_N_WAIT: addr = wa(n_ff);
         S_R_N_MERGE: begin
            h_in = rd_data;
            if (!rd_data.used) begin
               o_in.size = o_ff.size + rd_data.size + HDR_S;
               wr_en = 1'b1;
               addr  = wa(off_ff);
               wr_data = o_ff;
               wr_data.size = o_ff.size + rd_data.size + HDR_S;
            end
         end
         S_R_NN_RD: begin
            nb_in = n_ff + HDR_S + h_ff.size;
            addr  = wa(n_ff + HDR_S + h_ff.size);
         end
         S_R_NN_WAIT: addr = wa(nb_ff);
         S_R_NN_WR: begin
            wr_en = 1'b1;
            addr  = wa(nb_ff);
            wr_data = rd_data;
            wr_data.prev = OW'(off_ff);
         end
         S_R_N_CLR: begin
            wr_en = 1'b1;
            addr  = wa(n_ff);
         end
         S_R_P_RD:   addr = wa(SW'(o_ff.prev));
         S_R_P_WAIT: addr = wa(SW'(o_ff.prev));
         S_R_P_CHK:  h_in = rd_data;
         S_R_A_RD: begin
            nb_in = next_o;
            addr  = wa(next_o);
         end
         S_R_A_WAIT: addr = wa(nb_ff);
         S_R_A_WR: begin
            wr_en = 1'b1;
            addr  = wa(nb_ff);
            wr_data = rd_data;
            wr_data.prev = o_ff.prev;
         end
         S_R_O_CLR: begin
            wr_en = 1'b1;
            addr  = wa(off_ff);
            h_in.size = h_ff.size + o_ff.size + HDR_S;
         end
         // predecessor header grows over the released block
         S_R_P_WR: begin
            wr_en = 1'b1;
            addr  = wa(SW'(o_ff.prev));
            wr_data = h_ff;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_in = rsp_ff;
               out_in.used_bytes = used_ff;
               out_in.free_bytes = free_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

### design/ffha_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_checker
// port-level checks of the heap allocator
// ----------------------------------------------------------------------------
module ffha_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ffha_pkg::rsp_type rsp_data
);
   import ffha_pkg::*;

   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while busy");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("beat changed while stalled");

   a_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE) |-> rsp_data.granted_offset == '0)
      else $error("offset on refused beat");

   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_ready, rsp_valid}) && (!rsp_valid || !$isunknown(rsp_data)))
      else $error("unknown handshake or beat");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
`default_nettype wire
